/* rtl/npt_pkg.sv */
`default_nettype none
package npt_pkg;
    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam int EntryW = 49;

    localparam logic [1:0] CmdAdd = 2'd0;
    localparam logic [1:0] CmdMark = 2'd1;
    localparam logic [1:0] CmdFind = 2'd2;
    localparam logic [1:0] CmdPurge = 2'd3;

    localparam logic [1:0] StDone = 2'd0;
    localparam logic [1:0] StFull = 2'd1;
    localparam logic [1:0] StNone = 2'd2;

    localparam logic [15:0] EatWindowReset = 16'd16;

    typedef struct packed {
        logic        start;
        logic [16:0] dx;
        logic [16:0] dy;
        logic [32:0] d2;
    } t_math_req;

    typedef struct packed {
        logic        done;
        logic [16:0] distance;
        logic [15:0] bearing;
    } t_math_rsp;

    function automatic logic [15:0] atan_lut(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0: v = 16'd8192;
            4'd1: v = 16'd4836;
            4'd2: v = 16'd2555;
            4'd3: v = 16'd1297;
            4'd4: v = 16'd651;
            4'd5: v = 16'd326;
            4'd6: v = 16'd163;
            4'd7: v = 16'd81;
            4'd8: v = 16'd41;
            4'd9: v = 16'd20;
            4'd10: v = 16'd10;
            4'd11: v = 16'd5;
            4'd12: v = 16'd3;
            4'd13: v = 16'd1;
            4'd14: v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

/* rtl/nearest_point_table.sv */
`default_nettype none
// Nearest point table. Points live in one synchronous RAM of TableDepth rows
// (x, y, value, eaten), read through a registered read port. An add has its
// result the cycle after it is accepted. Mark, find and purge walk the used
// rows in order at one row per cycle (the single read port paces this); a
// mark that hits stops early, and find then runs the square root / CORDIC
// unit on the nearest uneaten row, if any. Purge compacts in place: its
// write pointer never passes its read pointer, so no row is overwritten
// before it is read. The result sits in an output register; a new request
// is taken once that result has been handed off. Data read from table rows
// never written is never used. eat_window at byte address 0 (reset 16).
module nearest_point_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [15:0] i_query_x,
    input  wire logic [15:0] i_query_y,
    input  wire logic [15:0] i_new_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic             o_found,
    output logic [16:0]      o_near_distance,
    output logic [15:0]      o_near_bearing,
    output logic [15:0]      o_near_value,
    output logic [15:0]      o_near_x,
    output logic [15:0]      o_near_y,
    output logic [6:0]       o_uneaten_total
);
    import npt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MATH = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    // table memory
    logic [EntryW-1:0] mem [TableDepth];
    logic [EntryW-1:0] r_rd;
    logic              n_we;
    logic [IdxW-1:0]   n_waddr;
    logic [EntryW-1:0] n_wdata;
    logic [IdxW-1:0]   n_raddr;

    always_ff @(posedge i_clk) begin
        if (n_we) mem[n_waddr] <= n_wdata;
        r_rd <= mem[n_raddr];
    end

    logic [15:0]     r_win;
    logic [2:0]      r_st;
    logic [1:0]      r_cmd;
    logic [15:0]     r_qx, r_qy;
    logic [CntW-1:0] r_used, r_unea;
    logic [CntW-1:0] r_ri;     // next row to issue
    logic            r_rv;     // read data valid
    logic [CntW-1:0] r_wp;     // purge write pointer
    logic            r_have;
    logic [32:0]     r_best;
    logic [15:0]     r_bx, r_by, r_bv;
    logic            r_hit;
    t_math_req       math_req;
    t_math_rsp       math_rsp;

    logic [15:0] ex, ey, ev;
    logic        eaten;
    logic [16:0] dx, dy, ax, ay;
    logic [32:0] d2;
    logic        issue_end;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_win} : 32'd0;

    assign o_ready = (r_st == S_IDLE);

    always_comb begin
        {ex, ey, ev, eaten} = r_rd;
        dx = {1'b0, ex} - {1'b0, r_qx};
        dy = {1'b0, ey} - {1'b0, r_qy};
        ax = dx[16] ? -dx : dx;
        ay = dy[16] ? -dy : dy;
        d2 = {1'b0, 32'($signed(dx) * $signed(dx))}
           + {1'b0, 32'($signed(dy) * $signed(dy))};
        issue_end = (r_ri >= r_used);
        n_raddr = r_ri[IdxW-1:0];
        n_we = 1'b0;
        n_waddr = r_wp[IdxW-1:0];
        n_wdata = {ex, ey, ev, 1'b0};
        if (r_st == S_IDLE && i_valid && i_cmd == CmdAdd && r_used < CntW'(TableDepth)) begin
            n_we = 1'b1;
            n_waddr = r_used[IdxW-1:0];
            n_wdata = {i_query_x, i_query_y, i_new_value, 1'b0};
        end else if (r_st == S_SCAN && r_rv) begin
            if (r_cmd == CmdMark && !r_hit && !eaten
                    && ax < {1'b0, r_win} && ay < {1'b0, r_win}) begin
                n_we = 1'b1;
                n_waddr = r_ri[IdxW-1:0] - IdxW'(1);
                n_wdata = {ex, ey, ev, 1'b1};
            end else if (r_cmd == CmdPurge && !eaten) begin
                n_we = 1'b1;
            end
        end
        math_req.start = 1'b0;
        math_req.dx = {1'b0, r_bx} - {1'b0, r_qx};
        math_req.dy = {1'b0, r_by} - {1'b0, r_qy};
        math_req.d2 = r_best;
        if (r_st == S_SCAN && !r_rv && issue_end && r_cmd == CmdFind && r_have)
            math_req.start = 1'b1;
    end

    npt_math u_math (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (math_req),
        .o_rsp  (math_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= EatWindowReset;
            r_st <= S_IDLE;
            r_used <= '0;
            r_unea <= '0;
            r_rv <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == 1'b0)
                r_win <= pwdata[15:0];
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_qx <= i_query_x;
                        r_qy <= i_query_y;
                        r_ri <= '0;
                        r_rv <= 1'b0;
                        r_wp <= '0;
                        r_have <= 1'b0;
                        r_hit <= 1'b0;
                        {o_found, o_near_distance, o_near_bearing} <= '0;
                        {o_near_value, o_near_x, o_near_y} <= '0;
                        o_status <= StDone;
                        if (i_cmd == CmdAdd) begin
                            if (r_used < CntW'(TableDepth)) begin
                                r_used <= r_used + CntW'(1);
                                r_unea <= r_unea + CntW'(1);
                                o_uneaten_total <= 7'(r_unea + CntW'(1));
                            end else begin
                                o_status <= StFull;
                                o_uneaten_total <= 7'(r_unea);
                            end
                            o_valid <= 1'b1;
                            r_st <= S_OUT;
                        end else begin
                            r_st <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rv <= !issue_end && !r_hit;
                    if (!issue_end) r_ri <= r_ri + CntW'(1);
                    if (r_rv) begin
                        if (n_we && r_cmd == CmdMark) begin
                            r_hit <= 1'b1;
                            r_rv <= 1'b0;
                            r_ri <= r_used;
                        end
                        if (r_cmd == CmdPurge && !eaten) r_wp <= r_wp + CntW'(1);
                        if (r_cmd == CmdFind && !eaten && (!r_have || d2 < r_best)) begin
                            r_have <= 1'b1;
                            r_best <= d2;
                            r_bx <= ex;
                            r_by <= ey;
                            r_bv <= ev;
                        end
                    end else if (issue_end) begin
                        case (r_cmd)
                            CmdMark: begin
                                if (r_hit) begin
                                    r_unea <= r_unea - CntW'(1);
                                    o_found <= 1'b1;
                                    o_uneaten_total <= 7'(r_unea - CntW'(1));
                                end else begin
                                    o_status <= StNone;
                                    o_uneaten_total <= 7'(r_unea);
                                end
                                o_valid <= 1'b1;
                                r_st <= S_OUT;
                            end
                            CmdFind: begin
                                o_uneaten_total <= 7'(r_unea);
                                if (r_have) begin
                                    r_st <= S_MATH;
                                end else begin
                                    o_status <= StNone;
                                    o_valid <= 1'b1;
                                    r_st <= S_OUT;
                                end
                            end
                            default: begin
                                r_used <= r_wp;
                                r_unea <= r_wp;
                                o_uneaten_total <= 7'(r_wp);
                                o_valid <= 1'b1;
                                r_st <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MATH: begin
                    if (math_rsp.done) begin
                        o_found <= 1'b1;
                        o_near_distance <= math_rsp.distance;
                        o_near_bearing <= math_rsp.bearing;
                        o_near_value <= r_bv;
                        o_near_x <= r_bx;
                        o_near_y <= r_by;
                        o_valid <= 1'b1;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/npt_math.sv */
`default_nettype none
// Post-scan unit: restoring integer square root (one result bit per
// cycle) running alongside a 15-step CORDIC vectoring for the bearing.
module npt_math (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire npt_pkg::t_math_req i_req,
    output npt_pkg::t_math_rsp      o_rsp
);
    import npt_pkg::*;

    logic        r_busy;
    logic [4:0]  r_step;
    logic [33:0] r_rem;
    logic [33:0] r_src;
    logic [16:0] r_root;
    logic signed [26:0] r_x, r_y;
    logic signed [17:0] r_z;
    logic        r_zero;
    logic        r_done;

    logic [33:0] trial;
    logic [33:0] rem_sh;
    logic signed [26:0] xs, ys;
    logic [3:0]  ci;
    logic signed [26:0] x0, y0;
    logic signed [17:0] z0;
    logic signed [17:0] tab;

    always_comb begin
        x0 = $signed({{2{i_req.dx[16]}}, i_req.dx, 8'd0});
        y0 = $signed({{2{i_req.dy[16]}}, i_req.dy, 8'd0});
        z0 = 18'sd0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                x0 = $signed({{2{i_req.dy[16]}}, i_req.dy, 8'd0});
                y0 = -$signed({{2{i_req.dx[16]}}, i_req.dx, 8'd0});
                z0 = 18'sd16384;
            end else begin
                x0 = -$signed({{2{i_req.dy[16]}}, i_req.dy, 8'd0});
                y0 = $signed({{2{i_req.dx[16]}}, i_req.dx, 8'd0});
                z0 = -18'sd16384;
            end
        end
        ci = r_step[3:0];
        xs = r_x >>> ci;
        ys = r_y >>> ci;
        tab = $signed({2'b00, atan_lut(ci)});
        rem_sh = {r_rem[31:0], r_src[33:32]};
        trial = {15'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 5'd0;
                r_rem <= 34'd0;
                r_src <= {1'b0, i_req.d2};
                r_root <= 17'd0;
                r_x <= x0;
                r_y <= y0;
                r_z <= z0;
                r_zero <= (i_req.dx == 17'd0) && (i_req.dy == 17'd0);
            end else if (r_busy) begin
                // 17 root bits from a 33-bit (padded 34) radicand
                r_src <= {r_src[31:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem <= rem_sh - trial;
                    r_root <= {r_root[15:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_root <= {r_root[15:0], 1'b0};
                end
                if (r_step < 5'd15) begin
                    if (r_y >= 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + tab;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - tab;
                    end
                end
                r_step <= r_step + 5'd1;
                if (r_step == 5'd16) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.distance = r_root;
    assign o_rsp.bearing = r_zero ? 16'd0 : r_z[15:0];
endmodule
`default_nettype wire
